FILE: src/matrix3x3_inverse_core_assert.svh
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core_assert.svh
// Assertion macros shared by the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_CORE_ASSERT_SVH
`define MATRIX3X3_INVERSE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Widths, types and helpers of the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int IN_FRAC_BITS  = 12;
	localparam int OUT_FRAC_BITS = 16;

	localparam int A_W    = 16;
	localparam int PROD_W = 2 * A_W;
	localparam int COF_W  = PROD_W + 1;
	localparam int CMAG_W = PROD_W;
	localparam int DETP_W = A_W + COF_W;
	localparam int DET_W  = DETP_W + 2;
	localparam int DMAG_W = DET_W - 1;
	localparam int Q_W    = 32;
	localparam int OUT_W  = 32;
	localparam int N_ENT  = 9;

	localparam int DIV_SHIFT = IN_FRAC_BITS + OUT_FRAC_BITS;
	// Setup register, one register per quotient bit, result register.
	localparam int DIV_LAT   = Q_W + 2;

	localparam int PASS_SH = OUT_FRAC_BITS - IN_FRAC_BITS;
	localparam int PASS_SL = (PASS_SH >= 0) ? PASS_SH : 0;
	localparam int PASS_SR = (PASS_SH < 0) ? -PASS_SH : 0;

	typedef logic signed [A_W-1:0]   ent_t;
	typedef logic signed [OUT_W-1:0] res_t;

	typedef struct packed {
		logic [CMAG_W-1:0] mag;
		logic              neg;
	} div_req_t;

	// Input entry moved to the output fixed-point format, saturated.
	function automatic res_t pass_conv(input ent_t a);
		logic signed [63:0] w;
		logic signed [63:0] s;
		begin
			w = 64'(a);
			s = (w <<< PASS_SL) >>> PASS_SR;
			if (s > 64'sh7FFF_FFFF)
				pass_conv = res_t'(32'h7FFF_FFFF);
			else if (s < -64'sh8000_0000)
				pass_conv = res_t'(32'h8000_0000);
			else
				pass_conv = res_t'(s[OUT_W-1:0]);
		end
	endfunction

endpackage

FILE: src/m3i_div.sv
// ----------------------------------------------------------------------------
// m3i_div
// Pipelined restoring divider: |C| * 2^shift / |D|, signed, saturated.
// ----------------------------------------------------------------------------
module m3i_div (
	input  logic                          clk,
	input  logic                          en,
	input  m3i_pkg::div_req_t             req,
	input  logic [m3i_pkg::DMAG_W-1:0]    dmag,
	output m3i_pkg::res_t                 quot
);

	localparam int QW    = m3i_pkg::Q_W;
	localparam int DW    = m3i_pkg::DMAG_W;
	localparam int NW    = m3i_pkg::CMAG_W + m3i_pkg::DIV_SHIFT + 1;
	localparam int HI_W  = NW - QW;
	localparam int CMP_W = (HI_W > DW) ? HI_W : DW;

	logic [NW-1:0]    num_full;
	logic [CMP_W-1:0] hi_ext;
	logic [CMP_W-1:0] d_ext;

	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] low_s [0:QW];
	logic [QW-1:0] q_s   [0:QW];
	logic [DW-1:0] d_s   [0:QW];
	logic          big_s [0:QW];
	logic          neg_s [0:QW];

	logic [QW-1:0] quot_q;

	assign num_full = NW'(req.mag) << m3i_pkg::DIV_SHIFT;
	assign hi_ext   = CMP_W'(num_full[NW-1:QW]);
	assign d_ext    = CMP_W'(dmag);

	// The upper part of the numerator must stay below the divisor, else the
	// quotient does not fit in Q_W bits and saturates.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_ext[DW-1:0];
			low_s[0] <= num_full[QW-1:0];
			q_s[0]   <= '0;
			d_s[0]   <= dmag;
			big_s[0] <= (hi_ext >= d_ext);
			neg_s[0] <= req.neg;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0]   t;
		logic [DW+1:0] diff;
		logic          ge;

		assign t    = {rem_s[k], low_s[k][QW-1]};
		assign diff = {1'b0, t} - {2'b00, d_s[k]};
		assign ge   = ~diff[DW+1];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
				low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][QW-2:0], ge};
				d_s[k+1]   <= d_s[k];
				big_s[k+1] <= big_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QW]) begin
				if (big_s[QW] || (q_s[QW] > {1'b1, {(QW-1){1'b0}}}))
					quot_q <= {1'b1, {(QW-1){1'b0}}};
				else
					quot_q <= QW'(0) - q_s[QW];
			end else begin
				if (big_s[QW] || q_s[QW][QW-1])
					quot_q <= {1'b0, {(QW-1){1'b1}}};
				else
					quot_q <= q_s[QW];
			end
		end
	end

	assign quot = m3i_pkg::res_t'(quot_q);

endmodule

FILE: src/matrix3x3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Inverse of one 3x3 Q4.12 matrix per beat by the adjugate, Q16.16 result.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata: a11..a33, 16 bits each, a11 lowest
//  m_axis    out  tdata: inv11..inv33, 32 bits each, inv11 lowest;
//                 tuser: singular
//
// A new matrix is accepted in every cycle unless the output stalls. The path from input
// beat to output beat runs through six arithmetic stages, 34 divider stages (a setup
// stage, one stage per quotient bit for 32 bits, and a result stage) and the
// output register.
// Reset clears only the valid bits; the data registers are left as they are.
// While a finished output beat waits, the whole pipeline holds and s_axis
// tready is low, so no beat is lost or repeated.
//
module matrix3x3_inverse_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,   // a11,a12,a13,a21,a22,a23,a31,a32,a33
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [287:0] m_axis_tdata,   // inv11,inv12,...,inv33
	output logic         m_axis_tuser    // singular
);

	`include "matrix3x3_inverse_core_assert.svh"

	localparam int NE  = m3i_pkg::N_ENT;
	localparam int AW  = m3i_pkg::A_W;
	localparam int OW  = m3i_pkg::OUT_W;
	localparam int LAT = m3i_pkg::DIV_LAT;

	// Operand indexes of each cofactor: c = a[i0]*a[i1] - a[i2]*a[i3].
	localparam int COF_I [0:NE-1][0:3] = '{
		'{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
		'{5, 6, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 5, 0},
		'{3, 7, 6, 4}, '{1, 6, 7, 0}, '{0, 4, 3, 1}
	};

	// The whole pipeline moves when the output register is free or drained.
	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic dl_v [0:LAT-1];
	logic out_v_q;

	m3i_pkg::ent_t a_s1 [0:NE-1];
	m3i_pkg::ent_t a_s2 [0:NE-1];
	m3i_pkg::ent_t a_s3 [0:NE-1];
	m3i_pkg::ent_t a_s4 [0:NE-1];
	m3i_pkg::ent_t a_s5 [0:NE-1];
	m3i_pkg::ent_t a_s6 [0:NE-1];

	logic signed [m3i_pkg::PROD_W-1:0] p_s2 [0:NE-1][0:1];
	logic signed [m3i_pkg::COF_W-1:0]  c_s3 [0:NE-1];
	logic signed [m3i_pkg::DETP_W-1:0] dp_s4 [0:2];
	logic [m3i_pkg::CMAG_W-1:0]        cmag_s4 [0:NE-1];
	logic                              cneg_s4 [0:NE-1];
	logic [m3i_pkg::CMAG_W-1:0]        cmag_s5 [0:NE-1];
	logic                              cneg_s5 [0:NE-1];
	logic signed [m3i_pkg::DET_W-1:0]  det_s5;
	m3i_pkg::div_req_t                 req_s6 [0:NE-1];
	logic [m3i_pkg::DMAG_W-1:0]        dmag_s6;
	logic                              sing_s6;

	logic          dl_sing [0:LAT-1];
	m3i_pkg::ent_t dl_a    [0:LAT-1][0:NE-1];
	m3i_pkg::res_t quot    [0:NE-1];
	m3i_pkg::res_t out_q   [0:NE-1];
	logic          sing_q;

	assign adv           = ~out_v_q | m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = sing_q;

	for (genvar k = 0; k < NE; k++) begin : g_out
		assign m_axis_tdata[k*OW +: OW] = out_q[k];
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < LAT; i++)
				dl_v[i] <= 1'b0;
		end else if (adv) begin
			v_s1    <= s_axis_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			dl_v[0] <= v_s6;
			for (int i = 1; i < LAT; i++)
				dl_v[i] <= dl_v[i-1];
			out_v_q <= dl_v[LAT-1];
		end
	end

	// Stages 1 to 6: capture, 16x16 products, cofactors, determinant
	// partial products with cofactor magnitudes, determinant sum, and the
	// determinant magnitude with the quotient signs.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NE; k++) begin
				a_s1[k] <= m3i_pkg::ent_t'(s_axis_tdata[k*AW +: AW]);
				a_s2[k] <= a_s1[k];
				a_s3[k] <= a_s2[k];
				a_s4[k] <= a_s3[k];
				a_s5[k] <= a_s4[k];
				a_s6[k] <= a_s5[k];

				p_s2[k][0] <= a_s1[COF_I[k][0]] * a_s1[COF_I[k][1]];
				p_s2[k][1] <= a_s1[COF_I[k][2]] * a_s1[COF_I[k][3]];

				c_s3[k] <= m3i_pkg::COF_W'(p_s2[k][0]) - m3i_pkg::COF_W'(p_s2[k][1]);

				cneg_s4[k] <= c_s3[k][m3i_pkg::COF_W-1];
				cmag_s4[k] <= c_s3[k][m3i_pkg::COF_W-1]
					? m3i_pkg::CMAG_W'(-c_s3[k]) : m3i_pkg::CMAG_W'(c_s3[k]);

				cmag_s5[k] <= cmag_s4[k];
				cneg_s5[k] <= cneg_s4[k];

				req_s6[k].mag <= cmag_s5[k];
				req_s6[k].neg <= cneg_s5[k] ^ det_s5[m3i_pkg::DET_W-1];
			end

			// First-row expansion: det = a11*C11 + a12*C12 + a13*C13.
			dp_s4[0] <= a_s3[0] * c_s3[0];
			dp_s4[1] <= a_s3[1] * c_s3[3];
			dp_s4[2] <= a_s3[2] * c_s3[6];

			det_s5 <= m3i_pkg::DET_W'(dp_s4[0]) + m3i_pkg::DET_W'(dp_s4[1])
				+ m3i_pkg::DET_W'(dp_s4[2]);

			dmag_s6 <= det_s5[m3i_pkg::DET_W-1]
				? m3i_pkg::DMAG_W'(-det_s5) : m3i_pkg::DMAG_W'(det_s5);
			sing_s6 <= (det_s5 == '0);
		end
	end

	// Nine dividers share the enable and run alongside the delay line that
	// keeps the singular flag and the raw entries for pass-through.
	for (genvar k = 0; k < NE; k++) begin : g_div
		m3i_div u_div (
			.clk  (clk),
			.en   (adv),
			.req  (req_s6[k]),
			.dmag (dmag_s6),
			.quot (quot[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dl_sing[0] <= sing_s6;
			for (int k = 0; k < NE; k++)
				dl_a[0][k] <= a_s6[k];
			for (int i = 1; i < LAT; i++) begin
				dl_sing[i] <= dl_sing[i-1];
				for (int k = 0; k < NE; k++)
					dl_a[i][k] <= dl_a[i-1][k];
			end

			sing_q <= dl_sing[LAT-1];
			for (int k = 0; k < NE; k++)
				out_q[k] <= dl_sing[LAT-1]
					? m3i_pkg::pass_conv(dl_a[LAT-1][k]) : quot[k];
		end
	end

	// A waiting output beat must hold back the input side.
	`M3I_ASSERT_NOW(a_stall_blocks_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during output stall")
	// A held pipeline keeps its occupancy.
	`M3I_ASSERT_NEXT(a_hold_keeps_valid, !adv, v_s1 == $past(v_s1) && v_s6 == $past(v_s6) && dl_v[LAT-1] == $past(dl_v[LAT-1]), "pipeline valid changed while held")
	// An accepted beat enters the first stage.
	`M3I_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v_s1, "accepted beat not captured")

endmodule

FILE: dv/matrix3x3_inverse_checker.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_checker
// Watches both stream channels of the 3x3 inverse core. It predicts each
// inverse from the accepted input beat and compares it with the output beat.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_checker
	import m3i_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [287:0] m_axis_tdata,
	input  logic         m_axis_tuser,
	output int           mismatches,
	output int           outstanding
);

	typedef struct {
		res_t inv [N_ENT];
		logic singular;
	} inverse_t;

	inverse_t expected_inverses [$];
	int       beat_no;

	function automatic res_t sat32(input longint v);
		if (v > 64'sh7FFF_FFFF)
			return res_t'(32'h7FFF_FFFF);
		if (v < -64'sh8000_0000)
			return res_t'(32'h8000_0000);
		return res_t'(v[31:0]);
	endfunction

	// Cofactor * 2^(in+out frac) / det, truncated toward zero, saturated.
	function automatic res_t scaled_quotient(input longint num, input longint den);
		logic [63:0] nmag, dmag, q;
		logic        neg;
		neg  = (num < 0) != (den < 0);
		nmag = (num < 0) ? -num : num;
		dmag = (den < 0) ? -den : den;
		q    = (nmag << (IN_FRAC_BITS + OUT_FRAC_BITS)) / dmag;
		if (neg)
			return (q > 64'h8000_0000) ? res_t'(32'h8000_0000) : res_t'(-q);
		return (q > 64'h7FFF_FFFF) ? res_t'(32'h7FFF_FFFF) : res_t'(q);
	endfunction

	function automatic inverse_t invert_matrix(input logic [143:0] m);
		longint   a [N_ENT];
		longint   c [N_ENT];
		longint   det;
		inverse_t r;
		for (int k = 0; k < N_ENT; k++)
			a[k] = longint'(ent_t'(m[16*k +: 16]));
		c[0] = a[4]*a[8] - a[7]*a[5];
		c[1] = a[7]*a[2] - a[1]*a[8];
		c[2] = a[1]*a[5] - a[4]*a[2];
		c[3] = a[5]*a[6] - a[3]*a[8];
		c[4] = a[0]*a[8] - a[6]*a[2];
		c[5] = a[3]*a[2] - a[5]*a[0];
		c[6] = a[3]*a[7] - a[6]*a[4];
		c[7] = a[1]*a[6] - a[7]*a[0];
		c[8] = a[0]*a[4] - a[3]*a[1];
		det = a[0]*c[0] + a[1]*c[3] + a[2]*c[6];
		r.singular = (det == 0);
		for (int k = 0; k < N_ENT; k++) begin
			if (det != 0)
				r.inv[k] = scaled_quotient(c[k], det);
			else if (OUT_FRAC_BITS >= IN_FRAC_BITS)
				r.inv[k] = sat32(a[k] <<< (OUT_FRAC_BITS - IN_FRAC_BITS));
			else
				r.inv[k] = sat32(a[k] >>> (IN_FRAC_BITS - OUT_FRAC_BITS));
		end
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at output beat %0d: %s got %h expected %h",
			beat_no, what, got, want);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		beat_no    = 0;
	end

	assign outstanding = expected_inverses.size();

	always @(posedge clk) begin
		inverse_t e;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_inverses.push_back(invert_matrix(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_inverses.size() == 0) begin
					report("unexpected beat", m_axis_tdata[31:0], 0);
				end else begin
					e = expected_inverses.pop_front();
					for (int k = 0; k < N_ENT; k++)
						if (res_t'(m_axis_tdata[32*k +: 32]) !== e.inv[k])
							report($sformatf("inv%0d%0d", k/3 + 1, k%3 + 1),
								m_axis_tdata[32*k +: 32], e.inv[k]);
					if (m_axis_tuser !== e.singular)
						report("singular", m_axis_tuser, e.singular);
				end
				beat_no++;
			end
		end
	end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the 3x3 matrix inverse core: directed corner matrices, then
// random well-conditioned, singular, tiny and raw bit-pattern matrices,
// with bursty input and a stalling output. The checker gives the verdict data.
// ----------------------------------------------------------------------------
module tb;
	import m3i_pkg::*;

	localparam int RANDOM_ITEMS = 530;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [287:0] m_axis_tdata;
	logic         m_axis_tuser;
	int           mismatches;
	int           outstanding;
	int           sent = 0;
	logic         hold_off = 1'b0;

	always #1 clk = ~clk;

	matrix3x3_inverse_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	matrix3x3_inverse_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// Pack nine entries row-major, a11 in the lowest bits.
	function automatic logic [143:0] pack(input ent_t e [N_ENT]);
		logic [143:0] m;
		for (int k = 0; k < N_ENT; k++)
			m[16*k +: 16] = e[k];
		return m;
	endfunction

	function automatic logic [143:0] diag(input ent_t d, input ent_t off);
		ent_t e [N_ENT];
		for (int k = 0; k < N_ENT; k++)
			e[k] = (k % 4 == 0) ? d : off;
		return pack(e);
	endfunction

	// Kinds: raw bits, well-conditioned around plus or minus two, singular, tiny entries.
	function automatic logic [143:0] random_matrix();
		ent_t e [N_ENT];
		int   kind;
		kind = $urandom_range(9);
		for (int k = 0; k < N_ENT; k++) begin
			if (kind <= 2)
				e[k] = ent_t'($urandom);
			else if (kind <= 5)
				e[k] = ent_t'($urandom_range(8192)) - 4096
					+ ((k % 4 == 0) ? ent_t'($urandom_range(1) ? 8192 : -8192) : 0);
			else
				e[k] = ent_t'($urandom_range(8)) - 4;
		end
		if (kind == 6 || kind == 7) begin
			// Singular: a repeated row, a scaled row or a zero column.
			case ($urandom_range(2))
				0: for (int k = 0; k < 3; k++) e[6 + k] = e[k];
				1: for (int k = 0; k < 3; k++) e[3 + k] = -e[k];
				default: for (int k = 0; k < 3; k++) e[3*k + 1] = '0;
			endcase
		end
		return pack(e);
	endfunction

	task automatic send(input logic [143:0] m, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= m;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// The receiver stalls in its own rhythm, with stall-free stretches.
	always @(posedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else if ((sent / 64) % 3 == 1)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(3) != 0);
	end

	// One long output hold-off while input keeps coming, to fill the pipeline.
	initial begin
		wait (sent >= 150);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		ent_t         e [N_ENT];
		logic [143:0] corners [$];
		int           burst;
		int           gap;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		corners.push_back('0);
		corners.push_back(diag(16'sd4096, 16'sd0));
		corners.push_back(diag(16'sd32767, 16'sd32767));
		corners.push_back(diag(-16'sd32768, -16'sd32768));
		corners.push_back(diag(16'sd32767, 16'sd0));
		corners.push_back(diag(-16'sd32768, 16'sd0));
		corners.push_back(diag(16'sd1, 16'sd0));
		corners.push_back(diag(-16'sd1, 16'sd0));
		corners.push_back(diag(-16'sd32768, 16'sd32767));
		corners.push_back(diag(16'sd32767, -16'sd32768));
		corners.push_back({9{16'h5555}});
		corners.push_back({8{16'hAAAA}} << 16 | 144'h4000);
		e = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd10};
		corners.push_back(pack(e));
		e = '{16'sd0, 16'sd4096, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096};
		corners.push_back(pack(e));
		e = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, -16'sd32768, 16'sd32767,
			16'sd0, 16'sd0, 16'sd32767};
		corners.push_back(pack(e));
		e = '{16'sd2, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1};
		corners.push_back(pack(e));
		e = '{16'sd3, 16'sd6, 16'sd9, 16'sd1, 16'sd2, 16'sd3, -16'sd5, 16'sd7, 16'sd11};
		corners.push_back(pack(e));
		foreach (corners[i])
			send(corners[i], 0);

		burst = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			gap = 0;
			if (i == 300) begin
				// Drain fully, then resume.
				s_axis_tvalid <= 1'b0;
				while (outstanding != 0) @(posedge clk);
			end
			if (burst == 0) begin
				burst = $urandom_range(40, 1);
				gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			end
			burst--;
			send(random_matrix(), gap);
		end
		s_axis_tvalid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/m3i_pkg.sv
src/m3i_div.sv
src/matrix3x3_inverse_core.sv
dv/matrix3x3_inverse_checker.sv
dv/tb.sv
